// File: src/vdsf_pkg.sv
package vdsf_pkg;

    // block dimensions
    localparam int ID_CHARS    = 8;
    localparam int STAMP_BYTES = 24;
    localparam int ID_SLOTS    = 4;

    // derived widths
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int SLOT_CNT_W  = 3;
    localparam int ID_W        = 8 * ID_CHARS;
    localparam int ID_LEN_W    = $clog2(ID_CHARS + 2);
    localparam int ID_IDX_W    = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;
    localparam int STAMP_AW    = $clog2(STAMP_BYTES);
    localparam int STAMP_LEN_W = $clog2(STAMP_BYTES);
    localparam int IDX_W       = (STAMP_AW > ID_IDX_W) ? STAMP_AW : ID_IDX_W;

    // characters of the dump text
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0a;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ID_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ID_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ID_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ID_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 3'd4;

    typedef enum logic [1:0] {
        K_NONE,
        K_STAMP,
        K_CMD,
        K_VALUE
    } t_line_kind;

    typedef enum logic [2:0] {
        E_IDLE,
        E_STAMP,
        E_STAMP_NL,
        E_VALUE,
        E_ID,
        E_NL
    } t_emit_state;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

// File: src/vdsf_ram.sv
module vdsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/vdsf_idmatch.sv
module vdsf_idmatch (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  vdsf_pkg::t_cfg_wr        i_cfg,
    input  logic [vdsf_pkg::ID_W-1:0]     i_id_chars,
    input  logic [vdsf_pkg::ID_LEN_W-1:0] i_id_len,
    output logic                     o_kept
);
    import vdsf_pkg::*;

    logic [CFG_W-1:0]      r_keep [ID_SLOTS];
    logic [SLOT_CNT_W-1:0] r_count;
    logic                  hit;

    // kept id table, written by the user only while the block is idle, not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ID_SLOTS; k++) begin
                r_keep[k] <= '0;
            end
            r_count <= '0;
        end else if (i_cfg.we) begin
            for (int k = 0; k < ID_SLOTS; k++) begin
                if (i_cfg.index == CFG_KEEP_ID_0 + CFG_IDX_W'(k)) begin
                    r_keep[k] <= i_cfg.data;
                end
            end
            if (i_cfg.index == CFG_KEEP_COUNT) begin
                r_count <= i_cfg.data[SLOT_CNT_W-1:0];
            end
        end
    end

    // slots at or above the count are unused, a count above the table size uses all
    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < ID_SLOTS; k++) begin
            if (SLOT_CNT_W'(k) < r_count && r_keep[k] == CFG_W'(i_id_chars)) begin
                hit = 1'b1;
            end
        end
    end

    assign o_kept = hit && (i_id_len <= ID_LEN_W'(ID_CHARS));

endmodule

// File: src/waveform_dump_signal_filter.sv
// Value-change-dump signal filter. Bytes of dump text come in one request per
// cycle while the input is not stalled; each line is classed by its first
// byte: '#' lines are timestamps and are held in a small stamp memory as the
// pending timestamp, '$' lines are commands and are dropped, and any other
// line is a value change (value byte, then the signal id). Empty lines are
// skipped. On the newline of a value change whose id equals one of the kept
// ids (configuration registers 0..3, register 4 giving how many are in use)
// the block emits the pending timestamp line once, newline appended, then the
// value-change line; the last byte carries out_last. Timestamps beyond
// STAMP_BYTES-1 characters are cut and their bytes flagged stamp_truncated;
// ids longer than ID_CHARS never match. Every byte that causes no output is
// taken without holding off input. A matching newline holds off further input
// while the emitter walks its sequence at one output byte per cycle while the
// output side does not stall, fed by the stamp memory's registered read port.
// The next input is taken as soon as the final byte sits in the output
// register. Configuration must be written by the user only while idle; the
// block itself does not enforce it.
module waveform_dump_signal_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input byte stream
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_in_char,
    // filtered output stream
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_char,
    output logic                            o_out_last,
    output logic                            o_stamp_truncated,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [vdsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vdsf_pkg::CFG_W-1:0]      i_cfg_data
);
    import vdsf_pkg::*;

    // line parser state
    logic                   r_at_start, n_at_start;
    t_line_kind             r_kind, n_kind;
    logic [7:0]             r_value, n_value;
    logic [ID_W-1:0]        r_id_chars, n_id_chars;
    logic [ID_LEN_W-1:0]    r_id_len, n_id_len;
    logic [STAMP_LEN_W-1:0] r_stamp_len, n_stamp_len;
    logic                   r_stamp_ovf, n_stamp_ovf;

    // emitter state
    t_emit_state            r_emit, n_emit;
    logic [IDX_W-1:0]       r_idx, n_idx;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;
    logic                   r_out_trunc, n_out_trunc;

    logic                   in_acc;
    logic                   out_free;
    logic                   kept;
    logic                   start_emit;
    logic                   stamp_clear;
    logic                   ram_we;
    logic [STAMP_AW-1:0]    ram_waddr;
    logic [7:0]             ram_wdata;
    logic [7:0]             ram_rdata;
    logic [ID_W-1:0]        id_shift;
    logic                   emit_load;
    logic [7:0]             emit_char;
    logic                   emit_last;
    logic                   emit_trunc;
    t_cfg_wr                cfg_wr;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_emit != E_IDLE);

    assign cfg_wr.we    = i_cfg_we;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    vdsf_idmatch u_idmatch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_wr),
        .i_id_chars (r_id_chars),
        .i_id_len   (r_id_len),
        .o_kept     (kept)
    );

    // pending timestamp text; only entries below the stamp length are ever emitted
    vdsf_ram #(
        .WIDTH (8),
        .DEPTH (STAMP_BYTES)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx[STAMP_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // newline of a kept value-change line starts the emitter
    assign start_emit  = in_acc && !r_at_start && i_in_char == CH_NL
                         && r_kind == K_VALUE && kept;
    // pending timestamp is consumed once its newline has gone out
    assign stamp_clear = (r_emit == E_STAMP_NL) && out_free;

    // line parser
    always_comb begin
        n_at_start  = r_at_start;
        n_kind      = r_kind;
        n_value     = r_value;
        n_id_chars  = r_id_chars;
        n_id_len    = r_id_len;
        n_stamp_len = r_stamp_len;
        n_stamp_ovf = r_stamp_ovf;
        ram_we      = 1'b0;
        ram_waddr   = r_stamp_len[STAMP_AW-1:0];
        ram_wdata   = i_in_char;

        if (stamp_clear) begin
            n_stamp_len = '0;
            n_stamp_ovf = 1'b0;
        end

        if (in_acc) begin
            if (r_at_start) begin
                // empty lines are skipped
                if (i_in_char != CH_NL) begin
                    n_at_start = 1'b0;
                    if (i_in_char == CH_HASH) begin
                        // a new timestamp replaces the pending one at once
                        n_kind      = K_STAMP;
                        n_stamp_len = STAMP_LEN_W'(1);
                        n_stamp_ovf = 1'b0;
                        ram_we      = 1'b1;
                        ram_waddr   = '0;
                    end else if (i_in_char == CH_DOLLAR) begin
                        n_kind = K_CMD;
                    end else begin
                        n_kind     = K_VALUE;
                        n_value    = i_in_char;
                        n_id_chars = '0;
                        n_id_len   = '0;
                    end
                end
            end else if (i_in_char == CH_NL) begin
                n_kind     = K_NONE;
                n_at_start = 1'b1;
            end else if (r_kind == K_VALUE) begin
                if (r_id_len < ID_LEN_W'(ID_CHARS)) begin
                    n_id_chars = r_id_chars
                                 | (ID_W'(i_in_char) << {r_id_len, 3'b000});
                    n_id_len   = r_id_len + ID_LEN_W'(1);
                end else begin
                    // over-long id, saturate so it never matches
                    n_id_len = ID_LEN_W'(ID_CHARS + 1);
                end
            end else if (r_kind == K_STAMP) begin
                if (r_stamp_len < STAMP_LEN_W'(STAMP_BYTES - 1)) begin
                    ram_we      = 1'b1;
                    n_stamp_len = r_stamp_len + STAMP_LEN_W'(1);
                end else begin
                    n_stamp_ovf = 1'b1;
                end
            end
        end
    end

    // emitter next state; the read address is the next index so that the
    // memory output always holds the entry at the current index
    always_comb begin
        n_emit = r_emit;
        n_idx  = r_idx;
        case (r_emit)
            E_IDLE: begin
                if (start_emit) begin
                    n_emit = (r_stamp_len != '0) ? E_STAMP : E_VALUE;
                    n_idx  = '0;
                end
            end
            E_STAMP: begin
                if (out_free) begin
                    if (r_idx == IDX_W'(r_stamp_len - STAMP_LEN_W'(1))) begin
                        n_emit = E_STAMP_NL;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            E_STAMP_NL: begin
                if (out_free) begin
                    n_emit = E_VALUE;
                end
            end
            E_VALUE: begin
                if (out_free) begin
                    n_emit = (r_id_len == '0) ? E_NL : E_ID;
                    n_idx  = '0;
                end
            end
            E_ID: begin
                if (out_free) begin
                    if (r_idx == IDX_W'(r_id_len - ID_LEN_W'(1))) begin
                        n_emit = E_NL;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            E_NL: begin
                if (out_free) begin
                    n_emit = E_IDLE;
                end
            end
            default: begin
                n_emit = E_IDLE;
            end
        endcase
    end

    assign id_shift = r_id_chars >> {r_idx[ID_IDX_W-1:0], 3'b000};

    // emitter outputs
    always_comb begin
        emit_load  = 1'b0;
        emit_char  = CH_NL;
        emit_last  = 1'b0;
        emit_trunc = 1'b0;
        case (r_emit)
            E_IDLE: begin
                emit_load = 1'b0;
            end
            E_STAMP: begin
                emit_load  = out_free;
                emit_char  = ram_rdata;
                emit_trunc = r_stamp_ovf;
            end
            E_STAMP_NL: begin
                emit_load  = out_free;
                emit_trunc = r_stamp_ovf;
            end
            E_VALUE: begin
                emit_load = out_free;
                emit_char = r_value;
            end
            E_ID: begin
                emit_load = out_free;
                emit_char = id_shift[7:0];
            end
            E_NL: begin
                emit_load = out_free;
                emit_last = 1'b1;
            end
            default: begin
                emit_load = 1'b0;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_trunc = r_out_trunc;
        if (emit_load) begin
            n_out_valid = 1'b1;
            n_out_char  = emit_char;
            n_out_last  = emit_last;
            n_out_trunc = emit_trunc;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_kind      <= K_NONE;
            r_value     <= '0;
            r_id_chars  <= '0;
            r_id_len    <= '0;
            r_stamp_len <= '0;
            r_stamp_ovf <= 1'b0;
            r_emit      <= E_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_at_start  <= n_at_start;
            r_kind      <= n_kind;
            r_value     <= n_value;
            r_id_chars  <= n_id_chars;
            r_id_len    <= n_id_len;
            r_stamp_len <= n_stamp_len;
            r_stamp_ovf <= n_stamp_ovf;
            r_emit      <= n_emit;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_trunc <= n_out_trunc;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_char        = r_out_char;
    assign o_out_last        = r_out_last;
    assign o_stamp_truncated = r_out_trunc;

    // the closing newline is never a timestamp byte
    a_last_not_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> !r_out_trunc)
        else $error("last byte flagged as truncated timestamp");

    // stamp length stays inside the memory
    a_stamp_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stamp_len <= STAMP_LEN_W'(STAMP_BYTES - 1))
        else $error("stamp length beyond buffer");

    // timestamp is emitted once and then cleared
    a_stamp_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit == E_STAMP_NL) && out_free |=> r_stamp_len == '0 && !r_stamp_ovf)
        else $error("pending timestamp not cleared after emission");

    // emission only starts from an accepted newline of a value line
    a_start_on_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit == E_IDLE && n_emit != E_IDLE |-> in_acc && i_in_char == CH_NL
        && r_kind == K_VALUE)
        else $error("emission started without a value-line newline");

    // emitting a stamp needs a pending one
    a_stamp_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit == E_STAMP |-> r_stamp_len != '0)
        else $error("stamp emission with nothing pending");

endmodule

// File: bench/dump_filter_checker.sv
`timescale 1ns / 1ps

module dump_filter_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [7:0]                     i_in_char,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [7:0]                     i_out_char,
    input  logic                           i_out_last,
    input  logic                           i_stamp_truncated,
    input  logic                           i_cfg_we,
    input  logic [vdsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vdsf_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_bytes_checked
);
    import vdsf_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       cut;
    } t_filtered_byte;

    // own copy of the kept ids
    logic [ID_W-1:0]       slot_ids [ID_SLOTS];
    logic [SLOT_CNT_W-1:0] keep_count;

    // line parser state
    t_line_kind      kind;
    logic            at_start;
    logic [7:0]      value_ch;
    logic [ID_W-1:0] id_bits;
    int              id_len;
    logic [7:0]      stamp_mem [STAMP_BYTES];
    int              stamp_len;
    logic            stamp_cut;

    t_filtered_byte expected_bytes [$];
    int             mismatch_count;
    int             checked_count;
    int             pending_count;

    assign o_mismatches    = mismatch_count;
    assign o_pending       = pending_count;
    assign o_bytes_checked = checked_count;

    function automatic bit id_is_kept();
        int slots;
        bit hit;
        slots = (keep_count > ID_SLOTS) ? ID_SLOTS : int'(keep_count);
        hit   = 1'b0;
        if (id_len <= ID_CHARS) begin
            for (int k = 0; k < slots; k++) begin
                if (slot_ids[k] == id_bits) hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic push_byte(input logic [7:0] ch, input logic last, input logic cut);
        t_filtered_byte b;
        b.ch   = ch;
        b.last = last;
        b.cut  = cut;
        expected_bytes.push_back(b);
    endtask

    // works out the filtered bytes that one accepted request of dump text causes
    task automatic filter_byte(input logic [7:0] c);
        int i;
        if (at_start) begin
            // empty lines are skipped
            if (c != CH_NL) begin
                at_start = 1'b0;
                if (c == CH_HASH) begin
                    // a new timestamp replaces the pending one at once
                    kind         = K_STAMP;
                    stamp_cut    = 1'b0;
                    stamp_mem[0] = c;
                    stamp_len    = 1;
                end else if (c == CH_DOLLAR) begin
                    kind = K_CMD;
                end else begin
                    kind     = K_VALUE;
                    value_ch = c;
                    id_bits  = '0;
                    id_len   = 0;
                end
            end
        end else if (c == CH_NL) begin
            if (kind == K_VALUE && id_is_kept()) begin
                if (stamp_len > 0) begin
                    for (i = 0; i < stamp_len; i++) push_byte(stamp_mem[i], 1'b0, stamp_cut);
                    push_byte(CH_NL, 1'b0, stamp_cut);
                    stamp_len = 0;
                    stamp_cut = 1'b0;
                end
                push_byte(value_ch, 1'b0, 1'b0);
                for (i = 0; i < id_len && i < ID_CHARS; i++) begin
                    push_byte(id_bits[8*i +: 8], 1'b0, 1'b0);
                end
                push_byte(CH_NL, 1'b1, 1'b0);
            end
            kind     = K_NONE;
            at_start = 1'b1;
        end else if (kind == K_VALUE) begin
            // over-long ids saturate one past the limit and never match
            if (id_len < ID_CHARS) begin
                id_bits[8*id_len +: 8] = c;
                id_len++;
            end else begin
                id_len = ID_CHARS + 1;
            end
        end else if (kind == K_STAMP) begin
            if (stamp_len < STAMP_BYTES - 1) begin
                stamp_mem[stamp_len] = c;
                stamp_len++;
            end else begin
                stamp_cut = 1'b1;
            end
        end
    endtask

    task automatic note_mismatch(input string what, input t_filtered_byte want,
                                 input t_filtered_byte got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t mismatch %0d, %s: expected char %02h last %b cut %b,",
                     $realtime, mismatch_count, what, want.ch, want.last, want.cut);
            $display("    got char %02h last %b cut %b", got.ch, got.last, got.cut);
        end
    endtask

    // sampled mid-cycle: everything seen here moves at the next rising edge
    always @(negedge i_clk) begin : watch
        t_filtered_byte got;
        t_filtered_byte want;
        if (!i_rst_n) begin
            for (int k = 0; k < ID_SLOTS; k++) slot_ids[k] = '0;
            keep_count = '0;
            kind       = K_NONE;
            at_start   = 1'b1;
            value_ch   = '0;
            id_bits    = '0;
            id_len     = 0;
            stamp_len  = 0;
            stamp_cut  = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.ch   = i_out_char;
                got.last = i_out_last;
                got.cut  = i_stamp_truncated;
                if (expected_bytes.size() == 0) begin
                    note_mismatch("nothing expected", '0, got);
                end else begin
                    want = expected_bytes.pop_front();
                    checked_count++;
                    if (got.ch !== want.ch) note_mismatch("out_char", want, got);
                    else if (got.last !== want.last) note_mismatch("out_last", want, got);
                    else if (got.cut !== want.cut) note_mismatch("stamp_truncated", want, got);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEEP_ID_0:  slot_ids[0] = i_cfg_data;
                    CFG_KEEP_ID_1:  slot_ids[1] = i_cfg_data;
                    CFG_KEEP_ID_2:  slot_ids[2] = i_cfg_data;
                    CFG_KEEP_ID_3:  slot_ids[3] = i_cfg_data;
                    CFG_KEEP_COUNT: keep_count = i_cfg_data[SLOT_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) filter_byte(i_in_char);
        end
        pending_count = expected_bytes.size();
    end

endmodule

// File: bench/tb_waveform_dump_signal_filter.sv
`timescale 1ns / 1ps

module tb_waveform_dump_signal_filter;
    import vdsf_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_BYTES   = 42;   // minimum requests of dump text per random phase
    localparam int HOLD_CYCLES   = 300;  // long output hold to back the block up
    localparam int SETTLE_CYCLES = 40;   // longest emission is 34 bytes, plus margin
    localparam int IDLE_LIMIT    = 2000; // cycles with no request moving

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_in_char;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [7:0]           o_out_char;
    logic                 o_out_last;
    logic                 o_stamp_truncated;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int mismatches;
    int pending;
    int bytes_checked;

    // stimulus bookkeeping
    int requests_sent;
    int settings_loaded;
    bit calm_in;    // sender offers back to back
    bit calm_out;   // receiver never stalls
    bit hold_req;   // ask the receiver for its long hold
    bit hold_done;

    // what the stimulus believes is loaded, used to build matching lines
    logic [ID_W-1:0] keep_val [ID_SLOTS];
    int              keep_len [ID_SLOTS];
    int              keep_count;

    waveform_dump_signal_filter u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_char         (i_in_char),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_char        (o_out_char),
        .o_out_last        (o_out_last),
        .o_stamp_truncated (o_stamp_truncated),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    dump_filter_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_in_char         (i_in_char),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_out_char        (o_out_char),
        .i_out_last        (o_out_last),
        .i_stamp_truncated (o_stamp_truncated),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_bytes_checked   (bytes_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // any byte that does not end the line
    function automatic logic [7:0] id_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
        return b;
    endfunction

    // first byte of a value change: anything but a line, stamp or command opener
    function automatic logic [7:0] value_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_NL || b == CH_HASH || b == CH_DOLLAR);
        return b;
    endfunction

    // offer one request of dump text and hold it until the block takes it;
    // valid stays high into the next request unless a gap is drawn
    task automatic send_byte(input logic [7:0] b);
        int gap;
        bit taken;
        gap = calm_in ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= b;
        do begin
            // stall is settled by mid-cycle, so this is what the next edge sees
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        requests_sent++;
    endtask

    // drop valid, let every expected byte drain, then give the emitter time
    // to finish whatever it still holds before config may change
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // all five registers on back-to-back edges, write enable dropped after
    task automatic load_filter();
        for (int k = 0; k < ID_SLOTS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_KEEP_ID_0 + CFG_IDX_W'(k);
            i_cfg_data  <= keep_val[k];
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_KEEP_COUNT;
        i_cfg_data  <= CFG_W'(keep_count);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // fresh kept ids for a phase; the slot count walks the empty, single,
    // full and over-range settings and is random otherwise
    task automatic pick_filter(input int p);
        for (int k = 0; k < ID_SLOTS; k++) begin
            keep_len[k] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, ID_CHARS);
            keep_val[k] = '0;
            for (int i = 0; i < keep_len[k]; i++) keep_val[k][8*i +: 8] = id_byte();
        end
        case (p)
            1:       keep_count = 0;
            2:       keep_count = 1;
            3:       keep_count = ID_SLOTS;
            6:       keep_count = 7;
            default: keep_count = $urandom_range(0, 7);
        endcase
    endtask

    // one line of dump text; kept_only limits it to stamps and matching
    // value changes so that most lines reach the emitter
    task automatic emit_line(input bit kept_only);
        int r;
        int n;
        int s;
        int slots;
        slots = (keep_count > ID_SLOTS) ? ID_SLOTS : keep_count;
        if (kept_only) r = $urandom_range(0, 1) ? 0 : 60;
        else r = $urandom_range(0, 99);
        if (r < 45) begin
            // value change on a kept id, now and then spoilt by an extra byte
            send_byte(value_byte());
            if (slots > 0) begin
                s = $urandom_range(0, slots - 1);
                for (int i = 0; i < keep_len[s]; i++) send_byte(keep_val[s][8*i +: 8]);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(id_byte());
            end
            if ($urandom_range(0, 9) == 0) send_byte(id_byte());
            send_byte(CH_NL);
        end else if (r < 60) begin
            // value change on a random id, long ones included
            send_byte(value_byte());
            n = $urandom_range(0, ID_CHARS + 3);
            repeat (n) send_byte(id_byte());
            send_byte(CH_NL);
        end else if (r < 80) begin
            // timestamp, sometimes longer than the stamp memory
            send_byte(CH_HASH);
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 10) : $urandom_range(20, 30);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) send_byte(id_byte());
                else send_byte(8'h30 + 8'($urandom_range(0, 9)));
            end
            send_byte(CH_NL);
        end else if (r < 88) begin
            // command line, dropped by the block
            send_byte(CH_DOLLAR);
            n = $urandom_range(0, 8);
            repeat (n) send_byte(id_byte());
            send_byte(CH_NL);
        end else if (r < 95) begin
            send_byte(CH_NL);
        end else begin
            // raw noise, stray newlines and all
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            send_byte(CH_NL);
        end
    endtask

    // receiver side: runs of stalls and free cycles, one long hold on request,
    // and no stalls at all while the calm flag is up
    initial begin : out_stall_drive
        int  r;
        int  len;
        logic v;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                v         = 1'b1;
                len       = HOLD_CYCLES;
            end else if (calm_out) begin
                v   = 1'b0;
                len = 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    v   = 1'b0;
                    len = $urandom_range(1, 8);
                end else if (r < 90) begin
                    v   = 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    v   = 1'b1;
                    len = $urandom_range(8, 30);
                end
            end
            i_out_stall <= v;
            repeat (len) @(posedge i_clk);
        end
    end

    // watchdog: gives up once no request has moved on any channel for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) idle = 0;
            else idle++;
        end
        $display("no request moved for %0d cycles, giving up", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int sent_at;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_char   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty id kept in slot 0, a one-byte id, an all-ones id,
        // an id with a zero byte, and a slot count above the slot total
        keep_val[0] = '0;
        keep_len[0] = 0;
        keep_val[1] = 64'h21;
        keep_len[1] = 1;
        keep_val[2] = '1;
        keep_len[2] = ID_CHARS;
        keep_val[3] = 64'h7a00;
        keep_len[3] = 2;
        keep_count  = 7;
        load_filter();

        send_byte(CH_NL);                     // empty line, ignored
        send_byte(CH_HASH);                   // pending timestamp
        send_byte("9");
        send_byte(CH_NL);
        send_byte(CH_DOLLAR);                 // command, dropped
        send_byte("x");
        send_byte(CH_NL);
        send_byte("v");                       // empty id matches slot 0, stamp goes first
        send_byte(CH_NL);
        send_byte("1");                       // kept again, stamp already spent
        send_byte(8'h21);
        send_byte(CH_NL);
        send_byte("0");                       // widest id, every bit set
        repeat (ID_CHARS) send_byte(8'hff);
        send_byte(CH_NL);
        send_byte("b");                       // zero byte inside the id
        send_byte(8'h00);
        send_byte("z");
        send_byte(CH_NL);

        // random phases, each under its own filter setting
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            pick_filter(p);
            load_filter();
            calm_in  = (p == 5) || (p == 3);
            calm_out = (p == 5);
            // phase 3 keeps the output held while requests pour in
            if (p == 3) hold_req = 1'b1;
            sent_at = requests_sent;
            while (requests_sent - sent_at < PHASE_BYTES) emit_line(p == 3);
            calm_in  = 1'b0;
            calm_out = 1'b0;
        end
        wait_idle();

        $display("run covered %0d requests of dump text under %0d filter settings",
                 requests_sent, settings_loaded);
        $display("%0d filtered bytes checked, long output hold %s",
                 bytes_checked, hold_done ? "applied" : "not applied");
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
